>>> rtl/cansc_pkg.sv
`timescale 1ns / 1ps
package cansc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int PAYLOAD_BYTES = 8;
  localparam int WORD_W = 8 * PAYLOAD_BYTES;

  localparam logic [1:0] CMD_DECODE = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] payload;
    logic [5:0]  start_bit;
    logic [6:0]  bit_length;
    logic        motorola_order;
    logic        is_signed;
    logic [63:0] scale;
    logic [63:0] bias;
    logic [63:0] phys_min;
    logic [63:0] phys_max;
    logic [63:0] phys_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] decoded_value;
    logic [63:0] frame_bytes;
    logic        bad_descriptor;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item and prepare operands
    logic mul_step;  // one partial product
    logic div_step;  // one quotient bit
    logic finish;    // ends a clear, unused or bad item; clears the frame on clear
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       bad;
  } ctl_stat_t;

  function automatic logic [63:0] swap_bytes(input logic [63:0] w);
    logic [63:0] r;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      r[8*i +: 8] = w[8*(PAYLOAD_BYTES-1-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] field_mask(input logic [6:0] len);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (7'(i) < len);
    end
    return m;
  endfunction
endpackage

>>> rtl/cansc_if.sv
`timescale 1ns / 1ps
interface cansc_in_if;
  import cansc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cansc_out_if;
  import cansc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cansc_ctrl.sv
`timescale 1ns / 1ps
module cansc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cansc_pkg::ctl_cmd_t  cmd,
  input  cansc_pkg::ctl_stat_t stat
);
  import cansc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic [5:0] count, count_next;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    count_next = count;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // first cycle after load: choose the work path
        count_next = '0;
        if (stat.bad || stat.command == CMD_CLEAR || stat.command == CMD_UNUSED) begin
          cmd.finish = 1'b1;
          state_next = ST_OUT;
        end else if (stat.command == CMD_DECODE) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        count_next = count + 6'd1;
        if (count == 6'd3) begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next = count + 6'd1;
        if (count == 6'd63) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end
endmodule

>>> rtl/cansc_dpath.sv
`timescale 1ns / 1ps
module cansc_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  cansc_pkg::in_item_t  item,
  input  cansc_pkg::ctl_cmd_t  cmd,
  output cansc_pkg::ctl_stat_t stat,
  output cansc_pkg::out_item_t result
);
  import cansc_pkg::*;

  logic [1:0]   command;
  logic         bad;
  logic         motorola;
  logic [6:0]   len;
  logic [5:0]   shamt;
  logic         neg;
  logic [63:0]  opa;    // raw magnitude, or dividend magnitude
  logic [63:0]  opb;    // scale magnitude
  logic [63:0]  bias;
  logic [127:0] acc;    // product accumulator
  logic [1:0]   pidx;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic [63:0]  frame;
  logic         acc_done;

  // quotient with the final bit folded in, for the frame update on the last step
  logic        quo_last;
  logic [63:0] quo_n, placed_n;
  logic [5:0]  div_cnt;

  // descriptor check and placement
  logic [6:0]  mpos;
  logic        bad_c;
  logic [5:0]  sh_c;
  logic [63:0] word_c, raw_c, mask_c, smag_c, rmag_c;
  logic        rneg_c, sneg_c;
  logic [63:0] clamp_c, cu_c, bu_c, dmag_c;
  logic        dneg_c;

  always_comb begin
    mpos = 7'd56 - {1'b0, item.start_bit[5:3], 3'b000} + {4'd0, item.start_bit[2:0]};
    bad_c = (item.bit_length == 7'd0) || (item.bit_length > 7'd64) || (item.scale == '0);
    sh_c = item.start_bit;
    if (!item.motorola_order) begin
      if ({1'b0, item.start_bit} + {1'b0, item.bit_length} > 8'd64) bad_c = 1'b1;
    end else begin
      if (item.bit_length > mpos + 7'd1) bad_c = 1'b1;
      sh_c = 6'(mpos + 7'd1 - item.bit_length);
    end
    mask_c = field_mask(item.bit_length);
    word_c = item.motorola_order ? swap_bytes(item.payload) : item.payload;
    raw_c = (word_c >> sh_c) & mask_c;
    rneg_c = item.is_signed && raw_c[6'(item.bit_length - 7'd1)];
    rmag_c = rneg_c ? (64'd0 - (raw_c | ~mask_c)) : raw_c;
    sneg_c = item.scale[63];
    smag_c = sneg_c ? (64'd0 - item.scale) : item.scale;
    if ($signed(item.phys_value) < $signed(item.phys_min)) clamp_c = item.phys_min;
    else if ($signed(item.phys_value) > $signed(item.phys_max)) clamp_c = item.phys_max;
    else clamp_c = item.phys_value;
    cu_c = clamp_c ^ 64'h8000_0000_0000_0000;
    bu_c = item.bias ^ 64'h8000_0000_0000_0000;
    dneg_c = cu_c < bu_c;
    dmag_c = dneg_c ? (bu_c - cu_c) : (cu_c - bu_c);
  end

  // one 32x32 partial product per step
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  always_comb begin
    pa = pidx[0] ? opa[63:32] : opa[31:0];
    pb = pidx[1] ? opb[63:32] : opb[31:0];
    pp = pa * pb;
    pp_sh = {64'd0, pp} << {({1'b0, pidx[0]} + {1'b0, pidx[1]}), 5'd0};
  end

  // one restoring division bit per step
  logic [64:0] trial;
  always_comb begin
    trial = {rem, opa[63]} - {1'b0, opb};
  end

  // result forming
  logic [127:0] sprod, ssum;
  logic [63:0]  sat;
  always_comb begin
    sprod = neg ? (128'd0 - acc) : acc;
    ssum = sprod + {{64{bias[63]}}, bias};
    if (ssum[127:63] == {65{ssum[127]}}) sat = ssum[63:0];
    else sat = ssum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command <= item.command;
      bad <= bad_c && (item.command == CMD_DECODE || item.command == CMD_ENCODE);
      motorola <= item.motorola_order;
      len <= item.bit_length;
      shamt <= sh_c;
      bias <= item.bias;
      opb <= smag_c;
      acc <= '0;
      pidx <= '0;
      rem <= '0;
      quo <= '0;
      if (item.command == CMD_DECODE) begin
        opa <= rmag_c;
        neg <= rneg_c ^ sneg_c;
      end else begin
        opa <= dmag_c;
        neg <= dneg_c ^ sneg_c;
      end
    end
    if (cmd.mul_step) begin
      acc <= acc + pp_sh;
      pidx <= pidx + 2'd1;
    end
    if (cmd.div_step) begin
      opa <= {opa[62:0], 1'b0};
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], opa[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (cmd.finish && command == CMD_CLEAR) begin
      frame <= '0;
    end else if (cmd.div_step && quo_last) begin
      frame <= frame | (motorola ? swap_bytes(placed_n) : placed_n);
    end
  end

  assign quo_last = (div_cnt == 6'd63);
  always_ff @(posedge clk) begin
    if (cmd.load) div_cnt <= '0;
    else if (cmd.div_step) div_cnt <= div_cnt + 6'd1;
  end
  always_comb begin
    quo_n = {quo[62:0], ~trial[64]};
    placed_n = ((neg ? (64'd0 - quo_n) : quo_n) & field_mask(len)) << shamt;
  end

  assign stat.command = command;
  assign stat.bad = bad;
  assign result.decoded_value = (command == CMD_DECODE && !bad && pidx == 2'd0 &&
                                 acc_done) ? sat : 64'd0;
  assign result.frame_bytes = frame;
  assign result.bad_descriptor = bad;

  always_ff @(posedge clk) begin
    if (cmd.load) acc_done <= 1'b0;
    else if (cmd.mul_step && pidx == 2'd3) acc_done <= 1'b1;
  end
endmodule

>>> rtl/can_signal_codec_top.sv
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | command, payload, descriptor, scale, bias, limits, value
// out     | out | decoded_value, frame_bytes, bad_descriptor
// one item at a time; after the accepting cycle a check state picks the path:
// decode takes four 32x32 partial products on one shared multiplier, encode a
// 64-step restoring divider; clear, unused code or bad descriptor go straight
// to the result; a new item can be accepted in the cycle after the result transfer
// rst synchronous, active high, clears the controller and the frame to zero
// a stalled result holds until taken; no new transfer is accepted meanwhile
module can_signal_codec_top (
  input logic       clk,
  input logic       rst,
  cansc_in_if.sink  in_ch,
  cansc_out_if.source out_ch
);
  import cansc_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // controller sequences load, multiply or divide steps, and result transfer
  cansc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath holds operands, shared multiplier, divider and the frame register
  cansc_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch.data),
    .cmd    (cmd),
    .stat   (stat),
    .result (out_ch.data)
  );
endmodule

>>> tb/tb_can_signal_codec_top.sv
`timescale 1ns / 1ps
module tb_can_signal_codec_top;
  import cansc_pkg::*;

  logic clk;
  logic rst;

  cansc_in_if  in_ch();
  cansc_out_if out_ch();

  can_signal_codec_top uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q = 64'h1_0000;
  localparam int CYCLE_LIMIT = 400000;

  // predictor state: the frame being built by encode transfers
  logic [63:0] frame_shadow;
  out_item_t   pending_results[$];
  int          mismatch_count;
  int          cycle_count;
  bit          sink_stall_enable;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle counter guards against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // placement of the field's lowest bit; -1 when the field cannot fit
  function automatic int lsb_position(logic [5:0] start, logic [6:0] len, logic moto);
    int pos;
    if (len == 0 || len > 64) return -1;
    if (!moto) begin
      if (int'(start) + int'(len) > 64) return -1;
      return int'(start);
    end
    pos = 56 - 8 * (start >> 3) + (start & 7);
    if (int'(len) > pos + 1) return -1;
    return pos + 1 - int'(len);
  endfunction

  function automatic logic [63:0] reverse_bytes(logic [63:0] w);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = w[8*(7-i) +: 8];
    return r;
  endfunction

  function automatic logic [63:0] low_bits(logic [6:0] len);
    return (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
  endfunction

  // exact raw * scale + bias in 130-bit signed arithmetic, saturated to 64 bits
  function automatic logic [63:0] physical_from_raw(logic [63:0] word, int sh,
      logic [6:0] len, logic sgn, logic [63:0] scale, logic [63:0] bias);
    logic [63:0] m;
    logic [63:0] raw;
    logic signed [129:0] raw_w;
    logic signed [129:0] sum;
    m = low_bits(len);
    raw = (word >> sh) & m;
    if (sgn && raw[len - 1]) raw = raw | ~m;
    raw_w = sgn ? 130'(signed'(raw)) : signed'({66'd0, raw});
    sum = raw_w * 130'(signed'(scale)) + 130'(signed'(bias));
    if (sum > 130'(signed'(MAX64))) return MAX64;
    if (sum < 130'(signed'(MIN64))) return MIN64;
    return sum[63:0];
  endfunction

  // clamp, then (value - bias) / scale truncated toward zero, wrapping
  function automatic logic [63:0] raw_from_physical(logic [63:0] value,
      logic [63:0] vmin, logic [63:0] vmax, logic [63:0] scale, logic [63:0] bias);
    logic signed [65:0] c;
    logic signed [65:0] diff;
    logic signed [65:0] q;
    c = 66'(signed'(value));
    if (c < 66'(signed'(vmin))) c = 66'(signed'(vmin));
    else if (c > 66'(signed'(vmax))) c = 66'(signed'(vmax));
    diff = c - 66'(signed'(bias));
    q = diff / 66'(signed'(scale));
    return q[63:0];
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    int sh;
    logic [63:0] placed;
    r = '0;
    if (it.command == CMD_DECODE || it.command == CMD_ENCODE) begin
      sh = lsb_position(it.start_bit, it.bit_length, it.motorola_order);
      if (sh < 0 || it.scale == 0) begin
        r.bad_descriptor = 1'b1;
      end else if (it.command == CMD_DECODE) begin
        r.decoded_value = physical_from_raw(
            it.motorola_order ? reverse_bytes(it.payload) : it.payload,
            sh, it.bit_length, it.is_signed, it.scale, it.bias);
      end else begin
        placed = (raw_from_physical(it.phys_value, it.phys_min, it.phys_max,
                  it.scale, it.bias) & low_bits(it.bit_length)) << sh;
        frame_shadow |= it.motorola_order ? reverse_bytes(placed) : placed;
      end
    end else if (it.command == CMD_CLEAR) begin
      frame_shadow = '0;
    end
    r.frame_bytes = frame_shadow;
    return r;
  endfunction

  function automatic int gap_length();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transfer on the input channel, expectation queued on acceptance
  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_result(it));
  endtask

  // output side: random stalls, compare each transfer with the oldest expectation
  initial begin
    out_item_t want;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %p", out_ch.data);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.data !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: dec exp %h got %h, frame exp %h got %h, bad exp %b got %b",
                       want.decoded_value, out_ch.data.decoded_value,
                       want.frame_bytes, out_ch.data.frame_bytes,
                       want.bad_descriptor, out_ch.data.bad_descriptor);
          end
        end
      end
      out_ch.ready <= sink_stall_enable ? ($urandom_range(0, 99) < 70) : 1'b1;
    end
  end

  function automatic in_item_t random_descriptor(logic [1:0] cmd);
    in_item_t it;
    int mode;
    logic [63:0] lo;
    logic [63:0] hi;
    it.command = cmd;
    it.payload = {$urandom, $urandom};
    it.motorola_order = 1'($urandom_range(0, 1));
    it.is_signed = 1'($urandom_range(0, 1));
    it.start_bit = 6'($urandom_range(0, 63));
    // mostly short fields that fit, some wide, a few impossible
    mode = $urandom_range(0, 19);
    if (mode == 0) it.bit_length = 7'($urandom_range(0, 127));
    else if (mode < 4) it.bit_length = 7'($urandom_range(33, 64));
    else it.bit_length = 7'($urandom_range(1, 16));
    if (mode != 0) begin
      if (!it.motorola_order && int'(it.start_bit) + int'(it.bit_length) > 64)
        it.start_bit = 6'(64 - int'(it.bit_length));
      if (it.motorola_order &&
          lsb_position(it.start_bit, it.bit_length, 1'b1) < 0)
        it.start_bit = 6'd7;
    end
    mode = $urandom_range(0, 9);
    if (mode == 0) it.scale = {$urandom, $urandom};
    else if (mode == 1) it.scale = '0;
    else it.scale = 64'(signed'($urandom_range(0, 1) ? 32'(int'($urandom_range(1, 200000)))
                                                      : -32'(int'($urandom_range(1, 200000)))));
    it.bias = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
              : 64'(signed'(32'($urandom)));
    lo = 64'(signed'(32'($urandom))) <<< $urandom_range(0, 16);
    hi = 64'(signed'(32'($urandom))) <<< $urandom_range(0, 16);
    if ($urandom_range(0, 4) != 0 && signed'(lo) > signed'(hi)) begin
      it.phys_min = hi;
      it.phys_max = lo;
    end else begin
      it.phys_min = lo;
      it.phys_max = hi;
    end
    if ($urandom_range(0, 7) == 0) begin
      it.phys_min = {$urandom, $urandom};
      it.phys_max = {$urandom, $urandom};
    end
    it.phys_value = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                    : (64'(signed'(32'($urandom))) <<< $urandom_range(0, 16));
    return it;
  endfunction

  function automatic in_item_t basic_item(logic [1:0] cmd, logic [5:0] sb,
      logic [6:0] len, logic moto, logic sgn);
    in_item_t it;
    it = '0;
    it.command = cmd;
    it.payload = 64'hFEDC_BA98_7654_3210;
    it.start_bit = sb;
    it.bit_length = len;
    it.motorola_order = moto;
    it.is_signed = sgn;
    it.scale = ONE_Q;
    it.phys_min = MIN64;
    it.phys_max = MAX64;
    return it;
  endfunction

  task automatic test_decode_extremes();
    in_item_t it;
    it = basic_item(CMD_DECODE, 6'd0, 7'd64, 1'b0, 1'b0);
    it.payload = '1;
    send_item(it);
    it.is_signed = 1'b1;
    send_item(it);
    // huge raw times huge scale saturates high and low
    it = basic_item(CMD_DECODE, 6'd0, 7'd64, 1'b0, 1'b0);
    it.payload = '1;
    it.scale = MAX64;
    it.bias = MAX64;
    send_item(it);
    it.is_signed = 1'b1;
    it.payload = MIN64;
    it.bias = MIN64;
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd7, 7'd64, 1'b1, 1'b1);
    it.scale = MIN64;
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd63, 7'd1, 1'b0, 1'b1);
    it.payload = MIN64;
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd56, 7'd1, 1'b1, 1'b0);
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd12, 7'd12, 1'b1, 1'b1);
    it.bias = ONE_Q;
    send_item(it);
  endtask

  task automatic test_bad_descriptors();
    in_item_t it;
    it = basic_item(CMD_DECODE, 6'd1, 7'd64, 1'b0, 1'b0);
    send_item(it);
    it = basic_item(CMD_ENCODE, 6'd0, 7'd0, 1'b0, 1'b0);
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd3, 7'd127, 1'b0, 1'b0);
    send_item(it);
    it = basic_item(CMD_ENCODE, 6'd0, 7'd2, 1'b1, 1'b0);
    send_item(it);
    it = basic_item(CMD_DECODE, 6'd4, 7'd4, 1'b0, 1'b0);
    it.scale = '0;
    send_item(it);
    // clear ignores the descriptor, unused code leaves the frame alone
    it = basic_item(CMD_CLEAR, 6'd63, 7'd0, 1'b0, 1'b0);
    send_item(it);
    it = basic_item(CMD_UNUSED, 6'd0, 7'd8, 1'b0, 1'b0);
    send_item(it);
  endtask

  task automatic test_encode_cases();
    in_item_t it;
    it = basic_item(CMD_ENCODE, 6'd0, 7'd8, 1'b0, 1'b0);
    it.phys_value = 64'd5 << 16;
    send_item(it);
    // value below min takes min even when min > max
    it = basic_item(CMD_ENCODE, 6'd15, 7'd8, 1'b1, 1'b1);
    it.phys_min = 64'd3 << 16;
    it.phys_max = 64'd1 << 16;
    it.phys_value = MIN64;
    send_item(it);
    it = basic_item(CMD_ENCODE, 6'd32, 7'd16, 1'b0, 1'b1);
    it.phys_value = MAX64;
    it.phys_max = 64'd100 << 16;
    it.scale = -64'sd32768;
    send_item(it);
    // quotient wraps: min minus a max bias over a scale of one LSB
    it = basic_item(CMD_ENCODE, 6'd0, 7'd64, 1'b0, 1'b1);
    it.scale = 64'd1;
    it.bias = MAX64;
    it.phys_value = MIN64;
    send_item(it);
    it = basic_item(CMD_ENCODE, 6'd63, 7'd64, 1'b1, 1'b0);
    it.scale = MIN64;
    it.phys_value = MAX64;
    send_item(it);
    it = basic_item(CMD_CLEAR, 6'd0, 7'd8, 1'b0, 1'b0);
    send_item(it);
  endtask

  task automatic test_random_mix(int count);
    in_item_t it;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      sink_stall_enable = ((n / 60) % 3) != 2;
      if (k < 45) it = random_descriptor(CMD_DECODE);
      else if (k < 88) it = random_descriptor(CMD_ENCODE);
      else if (k < 95) it = random_descriptor(CMD_CLEAR);
      else it = random_descriptor(CMD_UNUSED);
      send_item(it);
    end
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    sink_stall_enable = 1'b1;
    frame_shadow = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_decode_extremes();
    test_bad_descriptors();
    test_encode_cases();
    test_random_mix(430);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
